@@ rtl/md5_pkg.sv @@
// Constants, tables and round functions shared by the MD5 digest block.
package md5_pkg;

	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned WORD_AW     = $clog2(BLOCK_WORDS);

	typedef logic [31:0] word_t;
	typedef logic [WORD_AW-1:0] waddr_t;

	localparam word_t IV_A = 32'h67452301;
	localparam word_t IV_B = 32'hefcdab89;
	localparam word_t IV_C = 32'h98badcfe;
	localparam word_t IV_D = 32'h10325476;

	localparam logic [7:0] PAD_MARK  = 8'h80;
	localparam logic [5:0] PAD_START = 6'd56;
	localparam logic [5:0] LAST_POS  = 6'd63;
	localparam logic [5:0] LAST_RND  = 6'd63;

	localparam word_t K_TABLE [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] ROT_TABLE [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	// message word used by round i
	function automatic waddr_t msg_index(input logic [5:0] i);
		logic [3:0] j;
		j = i[3:0];
		case (i[5:4])
			2'd0: return j;
			2'd1: return j + {j[1:0], 2'b00} + 4'd1;
			2'd2: return j + {j[2:0], 1'b0} + 4'd5;
			default: return {j[0], 3'b000} - j;
		endcase
	endfunction

	function automatic word_t round_f(input logic [1:0] stage, input word_t b,
			input word_t c, input word_t d);
		case (stage)
			2'd0: return (b & c) | (~b & d);
			2'd1: return (b & d) | (c & ~d);
			2'd2: return b ^ c ^ d;
			default: return c ^ (b | ~d);
		endcase
	endfunction

	function automatic word_t rotl(input word_t v, input logic [4:0] s);
		logic [63:0] t;
		t = {v, v} << s;
		return t[63:32];
	endfunction

endpackage

@@ rtl/md5_if.sv @@
// Valid/ready channels for message bytes and digest words.
interface md5_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       end_of_message;

	modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
	modport sink   (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface md5_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [1:0]  word_number;
	logic        last_word;

	modport source (output valid, digest_word, word_number, last_word, input ready);
	modport sink   (input valid, digest_word, word_number, last_word, output ready);
endinterface

@@ rtl/md5_ram.sv @@
// Generic RAM, one write port and one registered read port.
module md5_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/md5_message_digest.sv @@
// MD5 digest engine: byte input channel, digest word output channel.
//
// msg carries one request per message byte (byte_valid) and marks the final
// request with end_of_message; an end request with byte_valid low is legal
// and gives the digest of whatever came before, including the empty message.
// While a block is filling, one byte is taken every cycle. Each 64th byte
// starts a compression that holds msg.ready low: a prep step loads the
// working words and issues the first block-RAM read, 64 rounds run at one
// per cycle (each round's message word is read from the 16 x 32 block RAM
// in the cycle before that round), and a final step folds the result into
// the chain. After end of message, padding is written at one byte per cycle,
// each block it fills followed by a compression, in one block or in two
// when the length spills into a second block. The four digest words then
// appear on digest, word 0 (A) first, last_word high on word 3; each waits
// until digest.ready takes it, and no new message byte is taken meanwhile.
// Once word 3 is taken the chain, bit count and fill position return to
// their initial values. arst_n resets the control state and chain words at
// once; block RAM contents are never used before they are rewritten.
module md5_message_digest (
	input  logic                clk,
	input  logic                arst_n,
	md5_msg_if.sink             msg,
	md5_digest_if.source        digest
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_PREP,
		S_COMP,
		S_FIN,
		S_OUT
	} state_t;

	state_t                state_q;
	md5_pkg::word_t        chain_q [4];
	logic [63:0]           bit_total_q;
	logic [5:0]            fill_q;
	logic [5:0]            rnd_q;
	logic [1:0]            word_cnt_q;
	logic                  pad_q;
	logic                  sent80_q;
	logic                  len_phase_q;
	logic                  last_blk_q;
	logic [31:0]           word_q;
	md5_pkg::word_t        a_q, b_q, c_q, d_q;

	logic                  take;
	logic                  put_en;
	logic [7:0]            put_data;
	logic [7:0]            pad_byte;
	logic                  len_phase;
	logic                  wrap;
	logic                  ram_we;
	md5_pkg::waddr_t       ram_waddr;
	md5_pkg::word_t        ram_wdata;
	md5_pkg::waddr_t       ram_raddr;
	md5_pkg::word_t        ram_rdata;
	md5_pkg::word_t        rnd_sum;
	md5_pkg::word_t        b_next;

	assign msg.ready = (state_q == S_IDLE);
	assign take      = msg.valid && msg.ready;

	assign len_phase = sent80_q && ((fill_q == md5_pkg::PAD_START) || len_phase_q);
	assign pad_byte  = !sent80_q ? md5_pkg::PAD_MARK :
		len_phase ? bit_total_q[{fill_q[2:0], 3'b000} +: 8] : 8'h00;
	assign put_en    = (take && msg.byte_valid) || (state_q == S_PAD);
	assign put_data  = (state_q == S_PAD) ? pad_byte : msg.data_byte;
	assign wrap      = put_en && (fill_q == md5_pkg::LAST_POS);

	assign ram_we    = put_en && (fill_q[1:0] == 2'd3);
	assign ram_waddr = fill_q[5:2];
	assign ram_wdata = {put_data, word_q[23:0]};
	assign ram_raddr = (state_q == S_COMP) ? md5_pkg::msg_index(rnd_q + 6'd1)
		: md5_pkg::msg_index(6'd0);

	md5_ram #(
		.WIDTH (32),
		.DEPTH (md5_pkg::BLOCK_WORDS)
	) u_block_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rnd_sum = a_q + md5_pkg::round_f(rnd_q[5:4], b_q, c_q, d_q)
		+ md5_pkg::K_TABLE[rnd_q] + ram_rdata;
	assign b_next  = b_q + md5_pkg::rotl(rnd_sum,
		md5_pkg::ROT_TABLE[{rnd_q[5:4], rnd_q[1:0]}]);

	assign digest.valid       = (state_q == S_OUT);
	assign digest.digest_word = chain_q[word_cnt_q];
	assign digest.word_number = word_cnt_q;
	assign digest.last_word   = (word_cnt_q == 2'd3);

	// partial word and working words
	always_ff @(posedge clk) begin
		if (put_en) begin
			word_q[{fill_q[1:0], 3'b000} +: 8] <= put_data;
		end
		if (state_q == S_PREP) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (state_q == S_COMP) begin
			a_q <= d_q;
			b_q <= b_next;
			c_q <= b_q;
			d_q <= c_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			chain_q[0]  <= md5_pkg::IV_A;
			chain_q[1]  <= md5_pkg::IV_B;
			chain_q[2]  <= md5_pkg::IV_C;
			chain_q[3]  <= md5_pkg::IV_D;
			bit_total_q <= '0;
			fill_q      <= '0;
			rnd_q       <= '0;
			word_cnt_q  <= '0;
			pad_q       <= 1'b0;
			sent80_q    <= 1'b0;
			len_phase_q <= 1'b0;
			last_blk_q  <= 1'b0;
		end else begin
			if (put_en) begin
				fill_q <= fill_q + 6'd1;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						if (msg.byte_valid) begin
							bit_total_q <= bit_total_q + 64'd8;
						end
						if (msg.end_of_message) begin
							pad_q       <= 1'b1;
							sent80_q    <= 1'b0;
							len_phase_q <= 1'b0;
							last_blk_q  <= 1'b0;
						end
						if (wrap) begin
							state_q <= S_PREP;
						end else if (msg.end_of_message) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					sent80_q    <= 1'b1;
					len_phase_q <= len_phase;
					if (wrap) begin
						last_blk_q <= len_phase;
						state_q    <= S_PREP;
					end
				end
				S_PREP: begin
					rnd_q   <= '0;
					state_q <= S_COMP;
				end
				S_COMP: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == md5_pkg::LAST_RND) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					word_cnt_q <= '0;
					if (last_blk_q) begin
						state_q <= S_OUT;
					end else if (pad_q) begin
						state_q <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (digest.ready) begin
						word_cnt_q <= word_cnt_q + 2'd1;
						if (word_cnt_q == 2'd3) begin
							chain_q[0]  <= md5_pkg::IV_A;
							chain_q[1]  <= md5_pkg::IV_B;
							chain_q[2]  <= md5_pkg::IV_C;
							chain_q[3]  <= md5_pkg::IV_D;
							bit_total_q <= '0;
							fill_q      <= '0;
							pad_q       <= 1'b0;
							sent80_q    <= 1'b0;
							len_phase_q <= 1'b0;
							last_blk_q  <= 1'b0;
							state_q     <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		msg.ready |-> !digest.valid)
		else $error("byte request taken while digest is pending");

	a_no_write_in_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMP) |-> !ram_we)
		else $error("block RAM written during compression");

	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		(digest.valid && digest.ready && !digest.last_word) |=>
		(digest.valid && (digest.word_number == $past(digest.word_number) + 2'd1)))
		else $error("digest words out of order");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(digest.valid && digest.ready && digest.last_word) |=>
		((fill_q == 6'd0) && (bit_total_q == 64'd0) && msg.ready))
		else $error("state not restored after digest");

	a_rounds_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_COMP) && (rnd_q == md5_pkg::LAST_RND)) |=> (state_q == S_FIN))
		else $error("compression did not finish after last round");
`endif

endmodule
